// ===== design/solt_pkg.sv =====
package solt_pkg;

  localparam int SIZE_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int ALPHA_BITS = 16;
  localparam int CFG_BITS = 32;
  localparam int IDX_BITS = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SIZE_START   = 3'd0,
    REG_SIZE_MID     = 3'd1,
    REG_SIZE_END     = 3'd2,
    REG_BREAK_FIRST  = 3'd3,
    REG_BREAK_SECOND = 3'd4,
    REG_MODE_BITS    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                 drop;
    logic                 square;
    logic [SIZE_BITS-1:0] wa;
    logic [SIZE_BITS-1:0] wb;
    logic [SIZE_BITS-1:0] ha;
    logic [SIZE_BITS-1:0] hb;
  } side_t;

endpackage

// ===== design/solt_front.sv =====
module solt_front import solt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [TIME_BITS-1:0]    age,
  input  logic [CFG_BITS-1:0]     size_start,
  input  logic [CFG_BITS-1:0]     size_mid,
  input  logic [CFG_BITS-1:0]     size_end,
  input  logic [TIME_BITS-1:0]    t1,
  input  logic [TIME_BITS-1:0]    t2,
  input  logic [1:0]              mode,
  output logic                    vld_r,
  output logic [TIME_BITS-1:0]    num_r,
  output logic [TIME_BITS-1:0]    den_r,
  output side_t                   side_r
);

  logic                 past;
  logic                 seg2;
  logic [TIME_BITS-1:0] lo;
  logic [TIME_BITS-1:0] hi;
  logic [CFG_BITS-1:0]  from;
  logic [CFG_BITS-1:0]  to;
  logic [TIME_BITS-1:0] num_nxt;
  logic [TIME_BITS-1:0] den_nxt;
  side_t                side_nxt;

  always_comb begin
    past = (age >= t2);
    seg2 = (age >= t1);
    lo   = seg2 ? t1 : '0;
    hi   = seg2 ? t2 : t1;
    from = seg2 ? size_mid : size_start;
    to   = seg2 ? size_end : size_mid;
    if (past) begin
      from    = size_end;
      to      = size_end;
      num_nxt = '0;
      den_nxt = TIME_BITS'(1);
    end else begin
      num_nxt = age - lo;
      den_nxt = hi - lo;
    end
    side_nxt.drop   = past & mode[0];
    side_nxt.square = mode[1];
    side_nxt.wa     = from[2*SIZE_BITS-1:SIZE_BITS];
    side_nxt.wb     = to[2*SIZE_BITS-1:SIZE_BITS];
    side_nxt.ha     = from[SIZE_BITS-1:0];
    side_nxt.hb     = to[SIZE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

// ===== design/solt_div.sv =====
module solt_div import solt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [TIME_BITS-1:0]    num,
  input  logic [TIME_BITS-1:0]    den,
  input  side_t                   in_side,
  output logic                    vld_o,
  output logic [ALPHA_BITS-1:0]   alpha_o,
  output side_t                   side_o
);

  logic                  vld_r  [ALPHA_BITS];
  logic [TIME_BITS-1:0]  rem_r  [ALPHA_BITS];
  logic [TIME_BITS-1:0]  den_r  [ALPHA_BITS];
  logic [ALPHA_BITS-1:0] q_r    [ALPHA_BITS];
  side_t                 side_r [ALPHA_BITS];

  for (genvar i = 0; i < ALPHA_BITS; i++) begin : g_step
    logic                  vld_in;
    logic [TIME_BITS-1:0]  rem_in;
    logic [TIME_BITS-1:0]  den_in;
    logic [ALPHA_BITS-1:0] q_in;
    side_t                 side_in;
    logic [TIME_BITS:0]    sh;
    logic                  ge;
    logic [TIME_BITS-1:0]  sub;
    logic [TIME_BITS-1:0]  rem_nxt;
    logic [ALPHA_BITS-1:0] q_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign q_in    = q_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      sh      = {rem_in, 1'b0};
      ge      = (sh >= {1'b0, den_in});
      sub     = sh[TIME_BITS-1:0] - den_in;
      rem_nxt = ge ? sub : sh[TIME_BITS-1:0];
      q_nxt   = {q_in[ALPHA_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        den_r[i]  <= den_in;
        q_r[i]    <= q_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign vld_o   = vld_r[ALPHA_BITS-1];
  assign alpha_o = q_r[ALPHA_BITS-1];
  assign side_o  = side_r[ALPHA_BITS-1];

endmodule

// ===== design/solt_blend.sv =====
module solt_blend import solt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [ALPHA_BITS-1:0]   alpha,
  input  side_t                   in_side,
  output logic                    vld_r,
  output logic [SIZE_BITS-1:0]    w_r,
  output logic [SIZE_BITS-1:0]    h_r,
  output logic                    drop_r
);

  localparam int PROD_BITS = SIZE_BITS + ALPHA_BITS;

  logic                 m_vld_r;
  side_t                m_side_r;
  logic                 w_up_r;
  logic                 h_up_r;
  logic [PROD_BITS-1:0] w_mag_r;
  logic [PROD_BITS-1:0] h_mag_r;

  logic                 w_up;
  logic                 h_up;
  logic [SIZE_BITS-1:0] w_dif;
  logic [SIZE_BITS-1:0] h_dif;

  logic [PROD_BITS-1:0] w_rnd;
  logic [PROD_BITS-1:0] h_rnd;
  logic [SIZE_BITS-1:0] w_fin;
  logic [SIZE_BITS-1:0] h_fin;
  logic [SIZE_BITS-1:0] w_nxt;
  logic [SIZE_BITS-1:0] h_nxt;

  always_comb begin
    w_up  = (in_side.wb >= in_side.wa);
    h_up  = (in_side.hb >= in_side.ha);
    w_dif = w_up ? in_side.wb - in_side.wa : in_side.wa - in_side.wb;
    h_dif = h_up ? in_side.hb - in_side.ha : in_side.ha - in_side.hb;
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r <= in_side;
      w_up_r   <= w_up;
      h_up_r   <= h_up;
      w_mag_r  <= PROD_BITS'(w_dif) * PROD_BITS'(alpha);
      h_mag_r  <= PROD_BITS'(h_dif) * PROD_BITS'(alpha);
    end
  end

  // rounding and final add
  always_comb begin
    w_rnd = w_mag_r + PROD_BITS'({ALPHA_BITS{1'b1}});
    h_rnd = h_mag_r + PROD_BITS'({ALPHA_BITS{1'b1}});
    w_fin = w_up_r ? m_side_r.wa + w_mag_r[PROD_BITS-1:ALPHA_BITS]
                   : m_side_r.wa - w_rnd[PROD_BITS-1:ALPHA_BITS];
    h_fin = h_up_r ? m_side_r.ha + h_mag_r[PROD_BITS-1:ALPHA_BITS]
                   : m_side_r.ha - h_rnd[PROD_BITS-1:ALPHA_BITS];
    if (m_side_r.drop) begin
      w_nxt = '0;
      h_nxt = '0;
    end else begin
      w_nxt = w_fin;
      h_nxt = m_side_r.square ? w_fin : h_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      drop_r <= m_side_r.drop;
    end
  end

endmodule

// ===== design/size_over_life_two_segment_top.sv =====
// Two-segment size-over-life interpolator. One particle age word (Q16.16) enters per
// cycle while the pipeline is not stalled, and its width/height (Q8.8) or drop flag
// leaves through a segment-selection stage, a one-bit-per-stage pipelined divider
// forming the Q0.16 blend factor, a multiply stage and a rounding/add stage that is
// also the output register. The whole pipeline holds while the result word is stalled,
// so the input stall follows the output stall. Configuration is taken on any cycle
// (cfg_ready is always high) and is sampled per word at pipeline entry; indexes past
// the register list are ignored.
module size_over_life_two_segment_top import solt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_BITS-1:0]  in_age,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SIZE_BITS-1:0]  out_width,
  output logic [SIZE_BITS-1:0]  out_height,
  output logic                  out_drop,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  logic [CFG_BITS-1:0]  size_start_r;
  logic [CFG_BITS-1:0]  size_mid_r;
  logic [CFG_BITS-1:0]  size_end_r;
  logic [TIME_BITS-1:0] break_first_r;
  logic [TIME_BITS-1:0] break_second_r;
  logic [1:0]           mode_r;

  logic                 en;
  logic                 f_vld;
  logic [TIME_BITS-1:0] f_num;
  logic [TIME_BITS-1:0] f_den;
  side_t                f_side;
  logic                 d_vld;
  logic [ALPHA_BITS-1:0] d_alpha;
  side_t                d_side;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_start_r   <= '0;
      size_mid_r     <= '0;
      size_end_r     <= '0;
      break_first_r  <= '0;
      break_second_r <= '0;
      mode_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_START:   size_start_r   <= cfg_data;
        REG_SIZE_MID:     size_mid_r     <= cfg_data;
        REG_SIZE_END:     size_end_r     <= cfg_data;
        REG_BREAK_FIRST:  break_first_r  <= cfg_data[TIME_BITS-1:0];
        REG_BREAK_SECOND: break_second_r <= cfg_data[TIME_BITS-1:0];
        REG_MODE_BITS:    mode_r         <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  solt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_valid),
    .age        (in_age),
    .size_start (size_start_r),
    .size_mid   (size_mid_r),
    .size_end   (size_end_r),
    .t1         (break_first_r),
    .t2         (break_second_r),
    .mode       (mode_r),
    .vld_r      (f_vld),
    .num_r      (f_num),
    .den_r      (f_den),
    .side_r     (f_side)
  );

  solt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .num     (f_num),
    .den     (f_den),
    .in_side (f_side),
    .vld_o   (d_vld),
    .alpha_o (d_alpha),
    .side_o  (d_side)
  );

  solt_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld),
    .alpha   (d_alpha),
    .in_side (d_side),
    .vld_r   (out_valid),
    .w_r     (out_width),
    .h_r     (out_height),
    .drop_r  (out_drop)
  );

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drop |-> out_width == '0 && out_height == '0)
    else $error("dropped word carries a size");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_width) && $stable(out_drop))
    else $error("stalled result changed");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

// ===== dv/size_over_life_two_segment_top_test.sv =====
`timescale 1ns / 1ps

module size_over_life_two_segment_top_test;
  import solt_pkg::*;

  localparam logic [IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
    logic                 drop;
  } size_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [TIME_BITS-1:0] in_age;
  logic out_valid;
  logic out_stall;
  logic [SIZE_BITS-1:0] out_width;
  logic [SIZE_BITS-1:0] out_height;
  logic out_drop;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  size_over_life_two_segment_top dut (.*);

  logic [31:0] sz_start, sz_mid, sz_end, brk_first, brk_second;
  logic [1:0] mode;

  logic [TIME_BITS-1:0] age_queue[$];
  size_word_t size_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_pct = 0;
  int stall_timer = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [SIZE_BITS-1:0] lerp_size(logic [SIZE_BITS-1:0] a,
      logic [SIZE_BITS-1:0] b, logic [63:0] alpha);
    logic [63:0] mag;
    if (b >= a) begin
      mag = 64'(b - a) * alpha;
      return a + SIZE_BITS'(mag >> 16);
    end else begin
      mag = 64'(a - b) * alpha;
      return a - SIZE_BITS'((mag + 64'hFFFF) >> 16);
    end
  endfunction

  function automatic size_word_t predict_size(logic [TIME_BITS-1:0] age);
    size_word_t r;
    logic [63:0] lo, hi, alpha;
    logic [31:0] from, to;
    r = '0;
    if (age >= brk_second) begin
      if (mode[0]) begin
        r.drop = 1'b1;
      end else begin
        r.width = sz_end[31:16];
        r.height = mode[1] ? sz_end[31:16] : sz_end[15:0];
      end
    end else begin
      if (age >= brk_first) begin
        lo = 64'(brk_first); hi = 64'(brk_second); from = sz_mid; to = sz_end;
      end else begin
        lo = 0; hi = 64'(brk_first); from = sz_start; to = sz_mid;
      end
      alpha = ((64'(age) - lo) << 16) / (hi - lo);
      r.width = lerp_size(from[31:16], to[31:16], alpha);
      r.height = mode[1] ? r.width : lerp_size(from[15:0], to[15:0], alpha);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) size_queue.push_back(predict_size(in_age));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (age_queue.size() > 0 && !hold) begin
        in_valid <= 1;
        in_age <= age_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    size_word_t want;
    if (out_valid && !out_stall && rst_n) begin
      if (size_queue.size() == 0) begin
        $display("%0t: unexpected result w=%h h=%h drop=%b", $time,
                 out_width, out_height, out_drop);
        errors++;
      end else begin
        want = size_queue.pop_front();
        if (out_width !== want.width) begin
          $display("%0t: width expected %h actual %h", $time, want.width, out_width);
          errors++;
        end
        if (out_height !== want.height) begin
          $display("%0t: height expected %h actual %h", $time, want.height, out_height);
          errors++;
        end
        if (out_drop !== want.drop) begin
          $display("%0t: drop expected %b actual %b", $time, want.drop, out_drop);
          errors++;
        end
      end
    end
    if (stall_timer == 0) begin
      stall_timer <= $urandom_range(100, 400);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 70;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_timer <= stall_timer - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SIZE_START: sz_start = value;
      REG_SIZE_MID: sz_mid = value;
      REG_SIZE_END: sz_end = value;
      REG_BREAK_FIRST: brk_first = value;
      REG_BREAK_SECOND: brk_second = value;
      REG_MODE_BITS: mode = value[1:0];
      default: ;
    endcase
    cfg_valid <= 0;
  endtask

  task automatic set_all(logic [31:0] s0, s1, s2, t1, t2, logic [1:0] m);
    write_reg(REG_SIZE_START, s0);
    write_reg(REG_SIZE_MID, s1);
    write_reg(REG_SIZE_END, s2);
    write_reg(REG_BREAK_FIRST, t1);
    write_reg(REG_BREAK_SECOND, t2);
    write_reg(REG_MODE_BITS, 32'(m));
  endtask

  task automatic drain();
    while (age_queue.size() > 0 || in_valid || size_queue.size() > 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic edge_ages();
    age_queue.push_back(0);
    age_queue.push_back(brk_first - 1);
    age_queue.push_back(brk_first);
    age_queue.push_back(brk_second - 1);
    age_queue.push_back(brk_second);
    age_queue.push_back(32'hFFFF_FFFF);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {16'hFFFF, 16'h0000};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_age();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return brk_first + $urandom_range(0, 8) - 4;
      2: return brk_second + $urandom_range(0, 8) - 4;
      3: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom_range(0, (brk_second > brk_first) ? brk_second : brk_first);
    endcase
  endfunction

  initial begin
    logic [31:0] t1, t2;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    sz_start = 0; sz_mid = 0; sz_end = 0; brk_first = 0; brk_second = 0; mode = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset values
    age_queue.push_back(0);
    age_queue.push_back(32'hFFFF_FFFF);
    drain();

    set_all(32'h0100_0200, 32'h0800_0040, 32'h0010_FFFF, 32'h0001_0000, 32'h0003_0000, 2'd0);
    edge_ages();
    drain();
    write_reg(REG_MODE_BITS, 32'd1);
    edge_ages();
    drain();
    write_reg(REG_MODE_BITS, 32'd2);
    edge_ages();
    drain();
    // ignored register indexes, then out-of-order breakpoints
    write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED_HI, 32'h0);
    set_all(32'hFFFF_FFFF, 32'h0, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_8000, 2'd3);
    edge_ages();
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: begin t1 = $urandom; t2 = $urandom; end
        1: begin t1 = 0; t2 = $urandom_range(1, 32'h0010_0000); end
        default: begin
          t1 = $urandom_range(1, 32'h0008_0000);
          t2 = t1 + $urandom_range(1, 32'h0008_0000);
        end
      endcase
      set_all(pick_size(), pick_size(), pick_size(), t1, t2, 2'(ph));
      for (int i = 0; i < 145; i++) begin
        age_queue.push_back(pick_age());
        if (ph == 4 && i == 70) begin
          while (age_queue.size() > 0) @(posedge clk);
          hold = 1;
          while (in_valid || size_queue.size() > 0) @(posedge clk);
          hold = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
